// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, masked during reset
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising edge, including reset cycles
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/cds_pkg.sv
package cds_pkg;

   localparam int METRIC_W = 64;

   // configuration register indexes
   localparam logic REG_CYCLE_LENGTH  = 1'b0;
   localparam logic REG_SPACING_LIMIT = 1'b1;

   // per-slot state codes
   localparam logic [1:0] DS_KEEP  = 2'd0;
   localparam logic [1:0] DS_DROP  = 2'd1;
   localparam logic [1:0] DS_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_LATCH,
      ST_CMP,
      ST_SEL,
      ST_REM,
      ST_OUT
   } state_type;

   // excluded frames sort as the largest metric
   function automatic logic [METRIC_W-1:0] sort_key(input logic force_max,
                                                    input logic [METRIC_W-1:0] metric);
      sort_key = force_max ? {METRIC_W{1'b1}} : metric;
   endfunction

endpackage

// File: rtl/core/cds_ram.sv
module cds_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/cycle_decimation_select.sv
// cycle decimation selector
// items arrive on the req_ ports, one per cycle slot, taken when start is high and busy
// is low. each item is stored in slot order; an item with req_last_item set starts the
// selection of the frames to drop and raises busy until all results are out.
// the selection ranks every slot against every other slot with one 64-bit comparator
// over the metric memory, then walks the ranked list with one candidate per cycle; each
// spacing retry adds a counting pass and another marking pass. the first result is out
// once the ranking and the marking passes are done, the rest back to back.
// results leave on the rsp_ ports, one per slot on consecutive cycles, each for
// exactly one cycle under rsp_valid; rsp_last_result marks the final slot. the receiver
// cannot stall, so nothing is held back. items that are not last produce no result and
// may follow each other on every cycle; busy drops during the final result cycle.
// csr_ writes set cycle_length (index 0) and spacing_limit (index 1); they take effect
// at once and are meant for idle periods.
// reset clears the gathered flags and marks, the slot counter and the registers
// (cycle_length 5, spacing_limit 0); the metric memory is not cleared and needs no pass.
module cycle_decimation_select
   import cds_pkg::*;
#(
   parameter int CYCLE_MAX = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [METRIC_W-1:0] req_frame_metric,
   input  logic                req_in_range,
   input  logic                req_forced_drop,
   input  logic                req_clip_start,
   input  logic [4:0]          req_drop_count,
   input  logic                req_last_item,
   output logic                rsp_valid,
   output logic [3:0]          rsp_slot_index,
   output logic [1:0]          rsp_drop_state,
   output logic [1:0]          rsp_shifted_state,
   output logic                rsp_select_error,
   output logic                rsp_last_result,
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [4:0]          csr_write_data
);

   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(CYCLE_MAX);
   localparam int CNT_W = $clog2(CYCLE_MAX + 1);
   localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
   localparam int WW    = CW + 2;
   localparam int SW    = CW + 2;

   state_type state_ff, state_in;

   logic [4:0]          cycle_length_ff, cycle_length_in;
   logic signed [4:0]   spacing_ff, spacing_in;
   logic [CNT_W-1:0]    slot_cnt_ff, slot_cnt_in;
   logic [CYCLE_MAX-1:0] range_ff, range_in;
   logic [CYCLE_MAX-1:0] forced_ff, forced_in;
   logic [CYCLE_MAX-1:0] clip_ff, clip_in;
   logic [CYCLE_MAX-1:0] drop_ff, drop_in;
   logic [CYCLE_MAX-1:0] shift_ff, shift_in;
   logic [IDX_W-1:0]    sorted_ff [CYCLE_MAX];
   logic [IDX_W-1:0]    sorted_in [CYCLE_MAX];
   logic [4:0]          drop_cnt_ff, drop_cnt_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic [CNT_W-1:0]    rank_ff, rank_in;
   logic [CNT_W-1:0]    n_in_ff, n_in_in;
   logic [CNT_W-1:0]    ovr_ff, ovr_in;
   logic [METRIC_W-1:0] keyi_ff, keyi_in;
   logic signed [SW-1:0] v_ff, v_in;
   logic signed [SW-1:0] target_ff, target_in;
   logic [4:0]          asd_ff, asd_in;
   logic                remany_ff, remany_in;
   logic                err_ff, err_in;

   logic                rsp_valid_in;
   logic [3:0]          rsp_slot_in;
   logic [1:0]          rsp_drop_in;
   logic [1:0]          rsp_shift_in;
   logic                rsp_err_in;
   logic                rsp_last_in;

   logic                accept;
   logic [CW-1:0]       len_w;
   logic [CNT_W-1:0]    len;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_raddr;
   logic [METRIC_W-1:0] ram_rdata;
   logic [IDX_W-1:0]    i_idx;
   logic [IDX_W-1:0]    j_idx;
   logic [IDX_W-1:0]    cand;
   logic [METRIC_W-1:0] keyj;
   logic                ranks_before;
   logic                spacing_ok;
   logic                shift_found;
   logic [IDX_W-1:0]    shift_pos;
   logic                sel_go;
   logic [CNT_W-1:0]    last_idx;
   logic [WW-1:0]       cand_w;
   logic [WW-1:0]       asd_w;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign i_idx    = i_ff[IDX_W-1:0];
   assign j_idx    = j_ff[IDX_W-1:0];
   assign cand     = sorted_ff[i_idx];
   assign last_idx = len - CNT_W'(1);

   // effective cycle length, clamped to 1..CYCLE_MAX
   always_comb begin
      if (cycle_length_ff == 5'd0) begin
         len_w = CW'(1);
      end else if (CW'(cycle_length_ff) > CW'(CYCLE_MAX)) begin
         len_w = CW'(CYCLE_MAX);
      end else begin
         len_w = CW'(cycle_length_ff);
      end
      len = len_w[CNT_W-1:0];
   end

   // metric memory
   assign ram_we = accept && (slot_cnt_ff < len);

   always_comb begin
      case (state_ff)
         ST_KEY:   ram_raddr = i_idx;
         ST_LATCH: ram_raddr = '0;
         default:  ram_raddr = IDX_W'(j_ff + CNT_W'(1));
      endcase
   end

   cds_ram #(
      .WIDTH(METRIC_W),
      .DEPTH(CYCLE_MAX)
   ) u_metric_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(slot_cnt_ff[IDX_W-1:0]),
      .wr_data(req_frame_metric),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // shared comparator: does slot j rank ahead of slot i
   assign keyj = sort_key(!range_ff[j_idx] || forced_ff[j_idx] || clip_ff[j_idx], ram_rdata);
   assign ranks_before = (keyj < keyi_ff) || ((keyj == keyi_ff) && (j_ff < i_ff));

   // spacing window around the candidate
   assign cand_w = WW'(cand);
   assign asd_w  = WW'(asd_ff);
   always_comb begin
      spacing_ok = 1'b1;
      for (int c = 0; c < CYCLE_MAX; c++) begin
         if (drop_ff[c] && (WW'(c) + asd_w >= cand_w) && (WW'(c) <= cand_w + asd_w)
             && (CNT_W'(c) < len)) begin
            spacing_ok = 1'b0;
         end
      end
   end

   // first free shifted slot at or after the candidate
   always_comb begin
      shift_found = 1'b0;
      shift_pos   = '0;
      for (int u = CYCLE_MAX - 1; u >= 0; u--) begin
         if ((IDX_W'(u) >= cand) && (CNT_W'(u) < len) && !shift_ff[u]) begin
            shift_found = 1'b1;
            shift_pos   = IDX_W'(u);
         end
      end
   end

   assign sel_go = (v_ff < target_ff) && (i_ff < n_in_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_item) state_in = ST_KEY;
         end
         ST_KEY:   state_in = ST_LATCH;
         ST_LATCH: state_in = ST_CMP;
         ST_CMP: begin
            if (j_ff == last_idx) begin
               state_in = (i_ff == last_idx) ? ST_SEL : ST_KEY;
            end
         end
         ST_SEL: begin
            if (!sel_go) state_in = (v_ff == target_ff) ? ST_OUT : ST_REM;
         end
         ST_REM: begin
            if (i_ff >= n_in_ff) begin
               state_in = (!remany_ff || asd_ff == 5'd0) ? ST_OUT : ST_SEL;
            end
         end
         ST_OUT: begin
            if (i_ff == last_idx) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cycle_length_in = cycle_length_ff;
      spacing_in      = spacing_ff;
      slot_cnt_in     = slot_cnt_ff;
      range_in        = range_ff;
      forced_in       = forced_ff;
      clip_in         = clip_ff;
      drop_in         = drop_ff;
      shift_in        = shift_ff;
      sorted_in       = sorted_ff;
      drop_cnt_in     = drop_cnt_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      rank_in         = rank_ff;
      n_in_in         = n_in_ff;
      ovr_in          = ovr_ff;
      keyi_in         = keyi_ff;
      v_in            = v_ff;
      target_in       = target_ff;
      asd_in          = asd_ff;
      remany_in       = remany_ff;
      err_in          = err_ff;
      rsp_valid_in    = 1'b0;
      rsp_slot_in     = 4'(i_ff);
      rsp_drop_in     = range_ff[i_idx] ? (drop_ff[i_idx] ? DS_DROP : DS_KEEP) : DS_RANGE;
      rsp_shift_in    = shift_ff[i_idx] ? DS_DROP : (range_ff[i_idx] ? DS_KEEP : DS_RANGE);
      rsp_err_in      = err_ff;
      rsp_last_in     = (i_ff == last_idx);

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            REG_CYCLE_LENGTH:  cycle_length_in = csr_write_data;
            REG_SPACING_LIMIT: spacing_in      = $signed(csr_write_data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (slot_cnt_ff < len) begin
                  range_in[slot_cnt_ff[IDX_W-1:0]]  = req_in_range;
                  forced_in[slot_cnt_ff[IDX_W-1:0]] = req_forced_drop;
                  clip_in[slot_cnt_ff[IDX_W-1:0]]   = req_clip_start;
                  slot_cnt_in = slot_cnt_ff + CNT_W'(1);
               end
               if (req_last_item) begin
                  drop_cnt_in = req_drop_count;
                  i_in        = '0;
                  n_in_in     = '0;
                  ovr_in      = '0;
                  err_in      = 1'b0;
               end
            end
         end
         // gather counts while ranking
         ST_KEY: begin
            n_in_in = n_in_ff + CNT_W'(range_ff[i_idx]);
            ovr_in  = ovr_ff + CNT_W'(range_ff[i_idx] && forced_ff[i_idx]);
         end
         ST_LATCH: begin
            keyi_in = sort_key(!range_ff[i_idx] || forced_ff[i_idx] || clip_ff[i_idx],
                               ram_rdata);
            rank_in = '0;
            j_in    = '0;
         end
         ST_CMP: begin
            rank_in = rank_ff + CNT_W'(ranks_before);
            j_in    = j_ff + CNT_W'(1);
            if (j_ff == last_idx) begin
               sorted_in[rank_in[IDX_W-1:0]] = i_idx;
               i_in = i_ff + CNT_W'(1);
               if (i_ff == last_idx) begin
                  drop_in   = range_ff & forced_ff;
                  shift_in  = range_ff & forced_ff;
                  v_in      = '0;
                  i_in      = '0;
                  target_in = $signed(SW'(drop_cnt_ff)) - $signed(SW'(ovr_ff));
                  asd_in    = (spacing_ff < 0) ? 5'(-spacing_ff) : 5'(spacing_ff);
               end
            end
         end
         // greedy marking pass over the ranked list
         ST_SEL: begin
            if (sel_go) begin
               if (range_ff[cand] && spacing_ok) begin
                  drop_in[cand] = 1'b1;
                  if (shift_found) shift_in[shift_pos] = 1'b1;
                  v_in = v_ff + SW'(1);
               end
               i_in = i_ff + CNT_W'(1);
            end else begin
               i_in      = '0;
               remany_in = 1'b0;
            end
         end
         // any unmarked candidate left
         ST_REM: begin
            if (i_ff < n_in_ff) begin
               if (range_ff[cand] && !drop_ff[cand]) remany_in = 1'b1;
               i_in = i_ff + CNT_W'(1);
            end else begin
               i_in = '0;
               if (!remany_ff || asd_ff == 5'd0) begin
                  err_in = 1'b1;
               end else if (spacing_ff < 0) begin
                  asd_in   = asd_ff - 5'd1;
                  drop_in  = range_ff & forced_ff;
                  shift_in = range_ff & forced_ff;
                  v_in     = '0;
               end else begin
                  asd_in = 5'd0;
               end
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            i_in = i_ff + CNT_W'(1);
            if (i_ff == last_idx) begin
               range_in    = '0;
               forced_in   = '0;
               clip_in     = '0;
               slot_cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cycle_length_ff <= 5'd5;
         spacing_ff      <= '0;
         slot_cnt_ff     <= '0;
         range_ff        <= '0;
         forced_ff       <= '0;
         clip_ff         <= '0;
         drop_ff         <= '0;
         shift_ff        <= '0;
         err_ff          <= 1'b0;
         rsp_valid       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cycle_length_ff <= cycle_length_in;
         spacing_ff      <= spacing_in;
         slot_cnt_ff     <= slot_cnt_in;
         range_ff        <= range_in;
         forced_ff       <= forced_in;
         clip_ff         <= clip_in;
         drop_ff         <= drop_in;
         shift_ff        <= shift_in;
         err_ff          <= err_in;
         rsp_valid       <= rsp_valid_in;
      end
      sorted_ff         <= sorted_in;
      drop_cnt_ff       <= drop_cnt_in;
      i_ff              <= i_in;
      j_ff              <= j_in;
      rank_ff           <= rank_in;
      n_in_ff           <= n_in_in;
      ovr_ff            <= ovr_in;
      keyi_ff           <= keyi_in;
      v_ff              <= v_in;
      target_ff         <= target_in;
      asd_ff            <= asd_in;
      remany_ff         <= remany_in;
      rsp_slot_index    <= rsp_slot_in;
      rsp_drop_state    <= rsp_drop_in;
      rsp_shifted_state <= rsp_shift_in;
      rsp_select_error  <= rsp_err_in;
      rsp_last_result   <= rsp_last_in;
   end

   // checks
   `ASSERT_IMPL(a_last_item_starts, clock, reset, accept && req_last_item |=> busy, "no start")
   `ASSERT_IMPL(a_results_burst, clock, reset, rsp_valid && !rsp_last_result |=> rsp_valid, "gap")
   `ASSERT_IMPL(a_burst_ends, clock, reset, rsp_valid && rsp_last_result |=> !rsp_valid, "extra")
   `ASSERT_IMPL(a_idle_after_burst, clock, reset, rsp_valid && rsp_last_result |-> !busy, "busy")

endmodule
